/* hw/rtl/qmi_pkg.sv */
// Shared types and constants for the sentence extractor.
`default_nettype none
package qmi_pkg;

  // Limits and framing sizes
  localparam int MAX_SENTENCE = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam int HDR_BYTES    = 7;
  localparam int RECHDR_BYTES = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WANTED_TYPE    = 2'd0;
  localparam logic [1:0] CFG_WANTED_MESSAGE = 2'd1;
  localparam logic [1:0] CFG_WANTED_KEY     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_WANTED_TYPE    = 8'd4;
  localparam logic [15:0] RST_WANTED_MESSAGE = 16'h0026;
  localparam logic [7:0]  RST_WANTED_KEY     = 8'd1;

  // One classified input beat: an optional payload byte, then an optional end result
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data;
    logic        has_end;
    logic        end_done;
    logic [15:0] length;
  } qmi_act_t;

endpackage
`default_nettype wire

/* hw/rtl/qmi_front.sv */
// Header and record parser: classifies each input byte into queued actions.
`default_nettype none
module qmi_front #(
  parameter int MAX_SENTENCE = qmi_pkg::MAX_SENTENCE
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_wdata,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             end_of_datagram,
  output logic                  push,
  output qmi_pkg::qmi_act_t     act
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_RECHDR  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_IGNORE  = 3'd4;

  localparam logic [15:0] HDR_LAST    = 16'(qmi_pkg::HDR_BYTES - 1);
  localparam logic [15:0] RECHDR_LAST = 16'(qmi_pkg::RECHDR_BYTES - 1);
  localparam logic [16:0] MAX_LEN     = 17'(MAX_SENTENCE);

  logic [7:0]  wanted_type_r;
  logic [15:0] wanted_message_r;
  logic [7:0]  wanted_key_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  htype_r, htype_nxt;
  logic [15:0] msg_id_r, msg_id_nxt;
  logic [7:0]  rkey_r, rkey_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic        done_r, done_nxt;
  logic [15:0] count_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r    <= qmi_pkg::RST_WANTED_TYPE;
      wanted_message_r <= qmi_pkg::RST_WANTED_MESSAGE;
      wanted_key_r     <= qmi_pkg::RST_WANTED_KEY;
    end else if (cfg_we) begin
      case (cfg_index)
        qmi_pkg::CFG_WANTED_TYPE:    wanted_type_r    <= cfg_wdata[7:0];
        qmi_pkg::CFG_WANTED_MESSAGE: wanted_message_r <= cfg_wdata;
        qmi_pkg::CFG_WANTED_KEY:     wanted_key_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign count_inc = count_r + 16'd1;

  // Parse one byte and build its action
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    htype_nxt  = htype_r;
    msg_id_nxt = msg_id_r;
    rkey_nxt   = rkey_r;
    rlen_nxt   = rlen_r;
    done_nxt   = done_r;
    act          = '0;
    act.data     = rx_byte;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          if (count_r == 16'd0) htype_nxt = rx_byte;
          if (count_r == 16'd3) msg_id_nxt[7:0] = rx_byte;
          if (count_r == 16'd4) msg_id_nxt[15:8] = rx_byte;
          count_nxt = count_inc;
          if (count_r == HDR_LAST) begin
            count_nxt = '0;
            phase_nxt = (htype_nxt == wanted_type_r && msg_id_nxt == wanted_message_r) ?
                        PH_RECHDR : PH_IGNORE;
          end
        end
        PH_RECHDR: begin
          if (count_r == 16'd0) rkey_nxt = rx_byte;
          else if (count_r == 16'd1) rlen_nxt[7:0] = rx_byte;
          else rlen_nxt[15:8] = rx_byte;
          count_nxt = count_inc;
          if (count_r == RECHDR_LAST) begin
            count_nxt = '0;
            if (rkey_nxt == wanted_key_r) begin
              if ({1'b0, rlen_nxt} > MAX_LEN) begin
                phase_nxt = PH_IGNORE;
              end else if (rlen_nxt == 16'd0) begin
                act.has_end  = 1'b1;
                act.end_done = 1'b1;
                done_nxt     = 1'b1;
                phase_nxt    = PH_IGNORE;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              phase_nxt = (rlen_nxt == 16'd0) ? PH_RECHDR : PH_SKIP;
            end
          end
        end
        PH_PAYLOAD: begin
          act.has_byte = 1'b1;
          count_nxt    = count_inc;
          if (count_inc >= rlen_r) begin
            act.has_end  = 1'b1;
            act.end_done = 1'b1;
            act.length   = rlen_r;
            done_nxt     = 1'b1;
            phase_nxt    = PH_IGNORE;
          end
        end
        PH_SKIP: begin
          count_nxt = count_inc;
          if (count_inc >= rlen_r) begin
            count_nxt = '0;
            phase_nxt = PH_RECHDR;
          end
        end
        default: ;
      endcase
      // Close the datagram on its end mark
      if (end_of_datagram) begin
        if (!done_nxt) begin
          act.has_end  = 1'b1;
          act.end_done = 1'b0;
          act.length   = '0;
        end
        phase_nxt  = PH_HEADER;
        count_nxt  = '0;
        htype_nxt  = '0;
        msg_id_nxt = '0;
        rkey_nxt   = '0;
        rlen_nxt   = '0;
        done_nxt   = 1'b0;
      end
    end
  end

  assign push = accept && (act.has_byte || act.has_end);

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      count_r  <= '0;
      htype_r  <= '0;
      msg_id_r <= '0;
      rkey_r   <= '0;
      rlen_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      htype_r  <= htype_nxt;
      msg_id_r <= msg_id_nxt;
      rkey_r   <= rkey_nxt;
      rlen_r   <= rlen_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qmi_queue.sv */
// Short action queue between the parser and the result emitter.
`default_nettype none
module qmi_queue #(
  parameter int DEPTH = qmi_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire qmi_pkg::qmi_act_t wr_data,
  input  wire logic              pop,
  output qmi_pkg::qmi_act_t      rd_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qmi_pkg::qmi_act_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  // Store the incoming action
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue fill count out of range");
`endif

endmodule
`default_nettype wire

/* hw/rtl/qmi_back.sv */
// Result emitter: turns queued actions into one output beat at a time.
`default_nettype none
module qmi_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qmi_pkg::qmi_act_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_byte,
  output logic [15:0]            out_sentence_length,
  output logic                   out_last_of_run
);

  logic        valid_r, valid_nxt;
  logic        sub_r, sub_nxt;
  logic        load;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] len_r, len_nxt;
  logic        last_r, last_nxt;

  assign load = !valid_r || !out_stall;

  // Pick the next result of the head action
  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    pop       = 1'b0;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        if (head.has_byte && !sub_r) begin
          kind_nxt = qmi_pkg::KIND_BYTE;
          byte_nxt = head.data;
          len_nxt  = '0;
          last_nxt = !head.has_end;
          if (head.has_end) sub_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          kind_nxt = head.end_done ? qmi_pkg::KIND_DONE : qmi_pkg::KIND_DROP;
          byte_nxt = '0;
          len_nxt  = head.end_done ? head.length : 16'd0;
          last_nxt = 1'b1;
          pop      = 1'b1;
          sub_nxt  = 1'b0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
  end

  assign out_valid           = valid_r;
  assign out_kind            = kind_r;
  assign out_byte            = byte_r;
  assign out_sentence_length = len_r;
  assign out_last_of_run     = last_r;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != qmi_pkg::KIND_BYTE) |-> last_r)
    else $error("end result not marked last of run");
  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!empty && head.has_end))
    else $error("second half of an action without its action");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && $stable(kind_r) && $stable(byte_r) &&
                                $stable(len_r) && $stable(last_r)))
    else $error("stalled result beat changed");
`endif

endmodule
`default_nettype wire

/* hw/rtl/qmi_tlv_sentence_extractor.sv */
// Top level of the sentence extractor: parser, action queue and emitter.
`default_nettype none
// Takes a datagram one byte per beat (end mark on the last byte), checks the
// 7-byte header against wanted_type and wanted_message, walks the records and
// passes on the value bytes of the first record keyed wanted_key, then a
// completion beat carrying its length; a datagram that yields no sentence
// gives one drop beat on its last byte. The parser accepts one byte per cycle
// while its action queue (QUEUE_DEPTH entries) has room; the emitter sends one
// result per cycle while out_stall is low, so a byte that causes two results
// is sent as two output beats. A result passes through the queue slot and then
// the emitter's output register. Configuration must be written only while no
// datagram is in flight; the block itself does not enforce this.
module qmi_tlv_sentence_extractor #(
  parameter int MAX_SENTENCE = qmi_pkg::MAX_SENTENCE,
  parameter int QUEUE_DEPTH  = qmi_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_end_of_datagram,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [15:0]      out_sentence_length,
  output logic             out_last_of_run
);

  qmi_pkg::qmi_act_t act, head;
  logic accept, push, pop, full, empty;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  qmi_front #(.MAX_SENTENCE(MAX_SENTENCE)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .accept          (accept),
    .rx_byte         (in_rx_byte),
    .end_of_datagram (in_end_of_datagram),
    .push            (push),
    .act             (act)
  );

  qmi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (act),
    .pop     (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  qmi_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .empty               (empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_sentence_length (out_sentence_length),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
`default_nettype wire
